@@ src/life_grid_generation_step_top_macros.svh @@
// Assertion macros shared by the checker of the Life grid block.
`ifndef LIFE_GRID_GENERATION_STEP_TOP_MACROS_SVH
`define LIFE_GRID_GENERATION_STEP_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LGS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lgs assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LGS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lgs assertion failed");

`endif

@@ src/lgs_pkg.sv @@
// Shared types, constants and functions of the Life grid block.
package lgs_pkg;

  localparam int MAX_ROWS_DEF  = 64;
  localparam int MAX_COLS_DEF  = 64;
  localparam int CFG_W         = 7;
  localparam int DATA_W        = 32;
  localparam int PADDR_W       = 3;
  localparam int MIN_DIM       = 3;
  localparam int SURVIVE_COUNT = 2;
  localparam int BIRTH_COUNT   = 3;
  localparam logic [CFG_W-1:0] GRID_RESET = CFG_W'(64);

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_STEP,
    KIND_READ,
    KIND_NONE
  } kind_t;

  typedef enum logic [1:0] {
    CLASS_DEAD,
    CLASS_ALIVE,
    CLASS_BORN,
    CLASS_DIED
  } class_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_STEP,
    ST_DRAIN
  } state_t;

  typedef enum logic {
    REG_ROWS,
    REG_COLS
  } reg_t;

  function automatic class_t class_of(logic cur, logic prev);
    class_t c;
    unique case ({cur, prev})
      2'b11:   c = CLASS_ALIVE;
      2'b10:   c = CLASS_BORN;
      2'b01:   c = CLASS_DIED;
      default: c = CLASS_DEAD;
    endcase
    return c;
  endfunction

  function automatic logic life_rule(logic old, logic [3:0] cnt);
    logic born;
    logic keep;
    born = (cnt == 4'(BIRTH_COUNT));
    keep = (cnt == 4'(SURVIVE_COUNT)) || born;
    return old ? keep : born;
  endfunction

endpackage

@@ src/life_grid_generation_step_top.sv @@
// Top level of the Life grid block: cell memory, command sequencer and register port.
//
//  Channel   Ports                                         Transfer when
//  command   start, busy, in_kind/row/col/cell_value       start && !busy
//  result    out_valid, out_reply_kind/alive/class/bad     out_valid (one cycle)
//  config    psel, penable, pwrite, paddr, pwdata, prdata  psel && penable && pwrite
//
// After reset the block clears all MAX_ROWS * 2**clog2(MAX_COLS) entries of the cell
// memory (4096 by default), one entry per cycle, with busy high.
// Writes, out-of-grid reads, unused commands and steps on a grid below 3x3 answer
// in the cycle after the transfer; a read inside the grid waits in ST_READ for
// the registered memory output. A step sweeps the grid one cell per cycle through
// the single read port of the cell memory and answers through ST_DRAIN.
// Results cannot be held off, so the block never stalls on the result side.
module life_grid_generation_step_top #(
  parameter int MAX_ROWS = lgs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = lgs_pkg::MAX_COLS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_kind,
  input  logic [5:0]                 in_row,
  input  logic [5:0]                 in_col,
  input  logic                       in_cell_value,
  output logic                       out_valid,
  output logic [1:0]                 out_reply_kind,
  output logic                       out_alive,
  output logic [1:0]                 out_change_class,
  output logic                       out_bad_address,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lgs_pkg::PADDR_W-1:0] paddr,
  input  logic [lgs_pkg::DATA_W-1:0]  pwdata,
  output logic [lgs_pkg::DATA_W-1:0]  prdata,
  output logic                       pready
);
  import lgs_pkg::*;

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = MAX_ROWS << CW;
  localparam int RXW   = ($clog2(MAX_ROWS + 1) > CFG_W) ? $clog2(MAX_ROWS + 1) : CFG_W;
  localparam int CXW   = ($clog2(MAX_COLS + 1) > CFG_W) ? $clog2(MAX_COLS + 1) : CFG_W;

  logic [CFG_W-1:0] grid_rows_r;
  logic [CFG_W-1:0] grid_cols_r;

  state_t state_r;
  state_t state_nxt;

  logic [1:0]  cell_mem [DEPTH];
  logic [1:0]  rd_q_r;
  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [1:0]  mem_wdata;

  logic [AW-1:0] clr_addr_r;
  logic [RW-1:0] row_r;
  logic [CW-1:0] col_r;
  logic          s1_valid_r;
  logic [RW-1:0] s1_row_r;
  logic [CW-1:0] s1_col_r;

  logic [RXW-1:0] rows_x;
  logic [CXW-1:0] cols_x;
  logic [RXW-1:0] eff_rows;
  logic [CXW-1:0] eff_cols;
  logic [RW-1:0]  last_row;
  logic [CW-1:0]  last_col;
  logic           small_grid;
  logic           in_grid;
  logic           accept;
  kind_t          kind_in;
  logic [AW-1:0]  item_addr;
  logic           sweep_last;
  logic           clr_last;

  logic          step_we;
  logic [AW-1:0] step_addr;
  logic          nxt_bit;
  logic          mid_bit;

  logic   out_valid_r;
  logic   out_valid_nxt;
  kind_t  out_kind_r;
  kind_t  out_kind_nxt;
  logic   out_alive_r;
  logic   out_alive_nxt;
  class_t out_class_r;
  class_t out_class_nxt;
  logic   out_bad_r;
  logic   out_bad_nxt;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= GRID_RESET;
      grid_cols_r <= GRID_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_t'(paddr[2]))
        REG_ROWS: grid_rows_r <= pwdata[CFG_W-1:0];
        REG_COLS: grid_cols_r <= pwdata[CFG_W-1:0];
      endcase
    end
  end

  assign pready = 1'b1;
  assign prdata = (reg_t'(paddr[2]) == REG_ROWS) ? DATA_W'(grid_rows_r) : DATA_W'(grid_cols_r);

  // Grid size in use and address decode.
  assign rows_x     = RXW'(grid_rows_r);
  assign cols_x     = CXW'(grid_cols_r);
  assign eff_rows   = (rows_x < RXW'(MAX_ROWS)) ? rows_x : RXW'(MAX_ROWS);
  assign eff_cols   = (cols_x < CXW'(MAX_COLS)) ? cols_x : CXW'(MAX_COLS);
  assign last_row   = RW'(eff_rows - RXW'(1));
  assign last_col   = CW'(eff_cols - CXW'(1));
  assign small_grid = (eff_rows < RXW'(MIN_DIM)) || (eff_cols < CXW'(MIN_DIM));
  assign in_grid    = (RXW'(in_row) < eff_rows) && (CXW'(in_col) < eff_cols);
  assign item_addr  = {RW'(in_row), CW'(in_col)};
  assign kind_in    = kind_t'(in_kind);
  assign accept     = start && !busy;
  assign sweep_last = (row_r == last_row) && (col_r == last_col);
  assign clr_last   = (clr_addr_r == AW'(DEPTH - 1));

  // Cell memory: bit 1 is the current state, bit 0 the previous one.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem[mem_waddr] <= mem_wdata;
    end
    rd_q_r <= cell_mem[mem_raddr];
  end

  lgs_window #(
    .MAX_COLS (MAX_COLS)
  ) u_window (
    .clk      (clk),
    .rd_col   (col_r),
    .s1_valid (s1_valid_r),
    .s1_col   (s1_col_r),
    .bot_bit  (rd_q_r[1]),
    .nxt_bit  (nxt_bit),
    .mid_bit  (mid_bit)
  );

  assign step_we   = s1_valid_r && (s1_row_r >= RW'(2)) && (s1_col_r >= CW'(2));
  assign step_addr = {s1_row_r - RW'(1), s1_col_r - CW'(1)};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (kind_in == KIND_READ && in_grid) begin
            state_nxt = ST_READ;
          end else if (kind_in == KIND_STEP && !small_grid) begin
            state_nxt = ST_STEP;
          end
        end
      end
      ST_READ: state_nxt = ST_IDLE;
      ST_STEP: begin
        if (sweep_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy          = (state_r != ST_IDLE);
    mem_we        = 1'b0;
    mem_waddr     = item_addr;
    mem_wdata     = 2'b00;
    mem_raddr     = item_addr;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_alive_nxt = out_alive_r;
    out_class_nxt = out_class_r;
    out_bad_nxt   = out_bad_r;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
      end
      ST_IDLE: begin
        if (accept) begin
          out_kind_nxt  = kind_in;
          out_alive_nxt = 1'b0;
          out_class_nxt = CLASS_DEAD;
          out_bad_nxt   = 1'b0;
          priority if (kind_in == KIND_WRITE) begin
            out_valid_nxt = 1'b1;
            out_bad_nxt   = !in_grid;
            if (in_grid) begin
              mem_we        = 1'b1;
              mem_wdata     = {in_cell_value, in_cell_value};
              out_alive_nxt = in_cell_value;
              out_class_nxt = class_of(in_cell_value, in_cell_value);
            end
          end else if (kind_in == KIND_READ) begin
            out_valid_nxt = !in_grid;
            out_bad_nxt   = !in_grid;
          end else if (kind_in == KIND_STEP) begin
            out_valid_nxt = small_grid;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_READ: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_READ;
        out_alive_nxt = rd_q_r[1];
        out_class_nxt = class_of(rd_q_r[1], rd_q_r[0]);
        out_bad_nxt   = 1'b0;
      end
      ST_STEP: begin
        mem_raddr = {row_r, col_r};
        mem_we    = step_we;
        mem_waddr = step_addr;
        mem_wdata = {nxt_bit, mid_bit};
      end
      ST_DRAIN: begin
        mem_we        = step_we;
        mem_waddr     = step_addr;
        mem_wdata     = {nxt_bit, mid_bit};
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_STEP;
        out_alive_nxt = 1'b0;
        out_class_nxt = CLASS_DEAD;
        out_bad_nxt   = 1'b0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      row_r       <= '0;
      col_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      s1_valid_r  <= (state_r == ST_STEP);
      out_valid_r <= out_valid_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (state_r == ST_IDLE) begin
        row_r <= '0;
        col_r <= '0;
      end else if (state_r == ST_STEP) begin
        if (col_r == last_col) begin
          col_r <= '0;
          row_r <= row_r + RW'(1);
        end else begin
          col_r <= col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_row_r    <= row_r;
    s1_col_r    <= col_r;
    out_kind_r  <= out_kind_nxt;
    out_alive_r <= out_alive_nxt;
    out_class_r <= out_class_nxt;
    out_bad_r   <= out_bad_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_reply_kind   = out_kind_r;
  assign out_alive        = out_alive_r;
  assign out_change_class = out_class_r;
  assign out_bad_address  = out_bad_r;

endmodule

@@ src/lgs_window.sv @@
// Line buffer and 3x3 neighborhood window that computes the next state of one cell.
module lgs_window #(
  parameter int MAX_COLS = lgs_pkg::MAX_COLS_DEF
) (
  input  logic                        clk,
  input  logic [$clog2(MAX_COLS)-1:0] rd_col,
  input  logic                        s1_valid,
  input  logic [$clog2(MAX_COLS)-1:0] s1_col,
  input  logic                        bot_bit,
  output logic                        nxt_bit,
  output logic                        mid_bit
);
  import lgs_pkg::*;

  logic [1:0] line_mem [MAX_COLS];
  logic [1:0] line_q_r;
  logic [2:0] win_a_r;
  logic [2:0] win_b_r;
  logic [2:0] col_t;
  logic [7:0] nbr;
  logic [3:0] cnt;

  // Bit 0 holds the older of the two buffered rows, bit 1 the newer one.
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      line_mem[s1_col] <= {bot_bit, line_q_r[1]};
    end
    line_q_r <= line_mem[rd_col];
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      win_a_r <= win_b_r;
      win_b_r <= col_t;
    end
  end

  assign col_t   = {bot_bit, line_q_r[1], line_q_r[0]};
  assign nbr     = {win_a_r, win_b_r[2], win_b_r[0], col_t};
  assign cnt     = 4'($countones(nbr));
  assign mid_bit = win_b_r[1];
  assign nxt_bit = life_rule(mid_bit, cnt);

endmodule

@@ src/lgs_checker.sv @@
// Port-level checker for the Life grid block and its bind to the top level.
`include "life_grid_generation_step_top_macros.svh"

module lgs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_kind,
  input logic       out_valid,
  input logic [1:0] out_reply_kind,
  input logic       out_alive,
  input logic [1:0] out_change_class,
  input logic       out_bad_address
);
  import lgs_pkg::*;

  `LGS_ASSERT_IMPLY(a_step_quiet, clk, rst_n, out_valid && out_reply_kind == KIND_STEP, !out_alive && out_change_class == CLASS_DEAD && !out_bad_address)
  `LGS_ASSERT_IMPLY(a_bad_quiet, clk, rst_n, out_valid && out_bad_address, !out_alive && out_change_class == CLASS_DEAD)
  `LGS_ASSERT_IMPLY(a_write_steady, clk, rst_n, out_valid && out_reply_kind == KIND_WRITE, out_alive ? out_change_class == CLASS_ALIVE : out_change_class == CLASS_DEAD)
  `LGS_ASSERT_NEXT(a_write_answer, clk, rst_n, start && !busy && in_kind == KIND_WRITE, out_valid && out_reply_kind == KIND_WRITE)

endmodule

bind life_grid_generation_step_top lgs_checker u_lgs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_kind          (in_kind),
  .out_valid        (out_valid),
  .out_reply_kind   (out_reply_kind),
  .out_alive        (out_alive),
  .out_change_class (out_change_class),
  .out_bad_address  (out_bad_address)
);
